>>> design/ilp_pkg.sv
`default_nettype none

package ilp_pkg;

  // Most values taken from one string, and most characters of a token that count.
  localparam int unsigned LIST_LIMIT  = 64;
  localparam int unsigned TOKEN_CHARS = 31;

  localparam int unsigned CNT_W = $clog2(LIST_LIMIT + 1);
  localparam int unsigned IDX_W = 6;
  localparam int unsigned LEN_W = $clog2(TOKEN_CHARS + 1);
  localparam int unsigned VAL_W = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef enum logic [2:0] {
    DEC_SKIP   = 3'b001,
    DEC_DIGITS = 3'b010,
    DEC_STOP   = 3'b100
  } dec_phase_t;

  typedef struct packed {
    logic             value_valid;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] value_index;
    logic             done_res;
    logic [CNT_W-1:0] value_count;
  } ilp_result_t;

endpackage

`default_nettype wire

>>> design/ilp_core.sv
`default_nettype none

module ilp_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ilp_pkg::CNT_W-1:0]  cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic [7:0]                 in_character,
  input  wire logic                       q_full,
  output logic                            res_push,
  output ilp_pkg::ilp_result_t            res_data
);

  logic [ilp_pkg::CNT_W-1:0]   max_r;
  logic                        in_valid_r;
  logic                        in_action_r;
  logic [7:0]                  in_char_r;

  logic                        list_phase_r,  list_phase_nxt;
  logic [ilp_pkg::LEN_W-1:0]   token_len_r,   token_len_nxt;
  logic                        hex_mode_r,    hex_mode_nxt;
  ilp_pkg::dec_phase_t         dec_phase_r,   dec_phase_nxt;
  logic                        hex_stopped_r, hex_stopped_nxt;
  logic                        first_zero_r,  first_zero_nxt;
  logic [ilp_pkg::VAL_W-1:0]   acc_r,         acc_nxt;
  logic [ilp_pkg::CNT_W-1:0]   count_r,       count_nxt;

  logic [ilp_pkg::CNT_W-1:0]   lim;
  logic                        is_end;
  logic                        is_dig;
  logic                        is_ws;
  logic                        is_hex;
  logic [3:0]                  nibble;
  logic [ilp_pkg::VAL_W-1:0]   dec_acc;
  ilp_pkg::dec_phase_t         dec_phase;
  logic                        fire;
  ilp_pkg::ilp_result_t        res;
  logic                        res_valid;

  always_comb begin
    is_dig = (in_char_r >= ilp_pkg::CH_ZERO) && (in_char_r <= ilp_pkg::CH_NINE);
    is_ws  = (in_char_r == ilp_pkg::CH_SPACE) ||
             ((in_char_r >= ilp_pkg::CH_TAB) && (in_char_r <= ilp_pkg::CH_CR));
    nibble = 4'd0;
    is_hex = 1'b1;
    if (is_dig) begin
      nibble = 4'(in_char_r - ilp_pkg::CH_ZERO);
    end else if ((in_char_r >= ilp_pkg::CH_LC_A) && (in_char_r <= ilp_pkg::CH_LC_F)) begin
      nibble = 4'(in_char_r - ilp_pkg::CH_LC_A + 8'd10);
    end else if ((in_char_r >= ilp_pkg::CH_UC_A) && (in_char_r <= ilp_pkg::CH_UC_F)) begin
      nibble = 4'(in_char_r - ilp_pkg::CH_UC_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Outcome of a decimal character, taken from the current decimal state.
  always_comb begin
    dec_acc   = acc_r;
    dec_phase = dec_phase_r;
    case (dec_phase_r)
      ilp_pkg::DEC_SKIP: begin
        if (!is_ws) begin
          if (is_dig) begin
            dec_acc   = {28'd0, nibble};
            dec_phase = ilp_pkg::DEC_DIGITS;
          end else begin
            dec_phase = ilp_pkg::DEC_STOP;
          end
        end
      end
      ilp_pkg::DEC_DIGITS: begin
        if (is_dig) begin
          dec_acc = (acc_r << 3) + (acc_r << 1) + {28'd0, nibble};
        end else begin
          dec_phase = ilp_pkg::DEC_STOP;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    list_phase_nxt  = list_phase_r;
    token_len_nxt   = token_len_r;
    hex_mode_nxt    = hex_mode_r;
    dec_phase_nxt   = dec_phase_r;
    hex_stopped_nxt = hex_stopped_r;
    first_zero_nxt  = first_zero_r;
    acc_nxt         = acc_r;
    count_nxt       = count_r;
    res             = '0;
    res_valid       = 1'b0;

    lim    = (max_r < ilp_pkg::CNT_W'(ilp_pkg::LIST_LIMIT)) ?
             max_r : ilp_pkg::CNT_W'(ilp_pkg::LIST_LIMIT);
    is_end = in_action_r || (in_char_r == ilp_pkg::CH_NUL);

    if (is_end) begin
      res_valid    = 1'b1;
      res.done_res = 1'b1;
      if (list_phase_r && (count_r < lim)) begin
        res.value_valid = 1'b1;
        res.value       = acc_r;
        res.value_index = count_r[ilp_pkg::IDX_W-1:0];
        res.value_count = count_r + 1'b1;
      end else begin
        res.value_count = count_r;
      end
      count_nxt = '0;
    end else if (count_r >= lim) begin
      // The limit is reached: the rest of the string is ignored.
    end else if (!list_phase_r && ((in_char_r == ilp_pkg::CH_SPACE) ||
                 (in_char_r == ilp_pkg::CH_TAB) || (in_char_r == ilp_pkg::CH_COMMA))) begin
    end else if (list_phase_r && (in_char_r == ilp_pkg::CH_COMMA)) begin
      res_valid       = 1'b1;
      res.value_valid = 1'b1;
      res.value       = acc_r;
      res.value_index = count_r[ilp_pkg::IDX_W-1:0];
      count_nxt       = count_r + 1'b1;
    end else begin
      list_phase_nxt = 1'b1;
      if (token_len_r < ilp_pkg::LEN_W'(ilp_pkg::TOKEN_CHARS)) begin
        token_len_nxt = token_len_r + 1'b1;
        if (token_len_r == '0) begin
          first_zero_nxt = (in_char_r == ilp_pkg::CH_ZERO);
          acc_nxt        = dec_acc;
          dec_phase_nxt  = dec_phase;
        end else if ((token_len_r == ilp_pkg::LEN_W'(1)) && first_zero_r &&
                     ((in_char_r == ilp_pkg::CH_LC_X) || (in_char_r == ilp_pkg::CH_UC_X))) begin
          hex_mode_nxt    = 1'b1;
          acc_nxt         = '0;
          hex_stopped_nxt = 1'b0;
        end else if (hex_mode_r) begin
          if (!hex_stopped_r) begin
            if (in_char_r == ilp_pkg::CH_SEMI) begin
              hex_stopped_nxt = 1'b1;
            end else if (is_hex) begin
              acc_nxt = {acc_r[ilp_pkg::VAL_W-5:0], nibble};
            end
          end
        end else begin
          acc_nxt       = dec_acc;
          dec_phase_nxt = dec_phase;
        end
      end
    end

    // A finished token or the end of a string starts the next token afresh.
    if (res_valid) begin
      list_phase_nxt  = 1'b0;
      token_len_nxt   = '0;
      hex_mode_nxt    = 1'b0;
      dec_phase_nxt   = ilp_pkg::DEC_SKIP;
      hex_stopped_nxt = 1'b0;
      first_zero_nxt  = 1'b0;
      acc_nxt         = '0;
    end
  end

  assign fire     = in_valid_r && (!res_valid || !q_full);
  assign in_ready = !in_valid_r || fire;
  assign res_push = fire && res_valid;
  assign res_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r      <= ilp_pkg::CNT_W'(ilp_pkg::LIST_LIMIT);
      in_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_action_r <= in_action;
      in_char_r   <= in_character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_phase_r  <= 1'b0;
      token_len_r   <= '0;
      hex_mode_r    <= 1'b0;
      dec_phase_r   <= ilp_pkg::DEC_SKIP;
      hex_stopped_r <= 1'b0;
      first_zero_r  <= 1'b0;
      acc_r         <= '0;
      count_r       <= '0;
    end else if (fire) begin
      list_phase_r  <= list_phase_nxt;
      token_len_r   <= token_len_nxt;
      hex_mode_r    <= hex_mode_nxt;
      dec_phase_r   <= dec_phase_nxt;
      hex_stopped_r <= hex_stopped_nxt;
      first_zero_r  <= first_zero_nxt;
      acc_r         <= acc_nxt;
      count_r       <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ilp_pkg::CNT_W'(ilp_pkg::LIST_LIMIT))
    else $error("value count passed the list limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_end |=> (count_r == '0) && !list_phase_r && (acc_r == '0))
    else $error("end of string left parse state behind");

  a_hex_in_token: assert property (@(posedge clk) disable iff (!rst_n)
    hex_mode_r |-> list_phase_r && (token_len_r >= ilp_pkg::LEN_W'(2)))
    else $error("hex mode outside a token");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !q_full)
    else $error("result pushed into a full queue");
`endif

endmodule

`default_nettype wire

>>> design/ilp_out_fifo.sv
`default_nettype none

module ilp_out_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  ilp_pkg::ilp_result_t       push_data,
  output logic                       full,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ilp_pkg::ilp_result_t       out_data
);

  ilp_pkg::ilp_result_t  mem [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            count_r, count_nxt;
  logic                  pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with the count");

  a_ptr_even: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == 2'd0) || (count_r == 2'd2)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with the count");
`endif

endmodule

`default_nettype wire

>>> design/integer_list_text_parser.sv
// A character accepted into the input register is parsed from there in a single pass; its
// transaction, if any, is written into the result queue and offered on the result port.
// Throughput: one character per cycle, except while a result waits on a full result queue.
// A two-entry result queue lets input keep flowing while a result waits.
// Reset (synchronous, rst_n low): parse state and counts clear, the value limit returns to 64.
`default_nettype none

module integer_list_text_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ilp_pkg::CNT_W-1:0]  cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic [7:0]                 in_character,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_value_valid,
  output logic [ilp_pkg::VAL_W-1:0]       out_value,
  output logic [ilp_pkg::IDX_W-1:0]       out_value_index,
  output logic                            out_done_res,
  output logic [ilp_pkg::CNT_W-1:0]       out_value_count
);

  logic                  q_full;
  logic                  res_push;
  ilp_pkg::ilp_result_t  res_data;
  ilp_pkg::ilp_result_t  out_data;

  ilp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_character (in_character),
    .q_full       (q_full),
    .res_push     (res_push),
    .res_data     (res_data)
  );

  ilp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_value_valid = out_data.value_valid;
  assign out_value       = out_data.value;
  assign out_value_index = out_data.value_index;
  assign out_done_res    = out_data.done_res;
  assign out_value_count = out_data.value_count;

endmodule

`default_nettype wire
